[hw/rtl/fpsr_pkg.sv]
// shared constants, opcodes and types for the frame parser stability ring
package fpsr_pkg;

  localparam int unsigned RingDepth = 16;
  localparam int unsigned RingAw    = $clog2(RingDepth);

  localparam logic [7:0] HeadA       = 8'hAA;
  localparam logic [7:0] HeadB       = 8'hBB;
  localparam logic [7:0] TailC       = 8'hCC;
  localparam logic [7:0] SideMax     = 8'd8;
  localparam logic [7:0] CountMax    = 8'hFF;
  localparam logic [7:0] RepeatReset = 8'd3;

  typedef enum logic [2:0] {
    OP_BYTE    = 3'd0,
    OP_ARM     = 3'd1,
    OP_RELEASE = 3'd2,
    OP_POP     = 3'd3,
    OP_LATEST  = 3'd4,
    OP_FLUSH   = 3'd5,
    OP_STABLE  = 3'd6,
    OP_PAIR    = 3'd7
  } op_e;

  typedef struct packed {
    logic [31:0] stamp;
    logic [3:0]  left;
    logic [3:0]  right;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic latest;
    logic flush;
  } ring_cmd_t;

  typedef struct packed {
    logic feed;
    logic arm;
    logic disarm;
  } det_cmd_t;

  typedef struct packed {
    logic   locked;
    logic   pair_flag;
    logic   locked_nxt;
    logic   pair_nxt;
    entry_t stable_entry;
    entry_t pair_entry;
  } det_stat_t;

endpackage

[hw/rtl/fpsr_parser.sv]
// byte-level frame parser with header restart and side range check
module fpsr_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       frame_ok_o,
  output logic [3:0] left_o,
  output logic [3:0] right_o
);
  import fpsr_pkg::*;

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhHeadB = 3'd1;
  localparam logic [2:0] PhLeft  = 3'd2;
  localparam logic [2:0] PhRight = 3'd3;
  localparam logic [2:0] PhTail  = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] right_q, right_d;
  logic       sides_ok;

  assign sides_ok = (left_q <= SideMax) && (right_q <= SideMax) &&
                    ((left_q != 8'd0) || (right_q != 8'd0));

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    right_d    = right_q;
    frame_ok_o = 1'b0;
    if (step_i) begin
      case (phase_q)
        PhHunt: begin
          if (byte_i == HeadA) phase_d = PhHeadB;
        end
        PhHeadB: begin
          if (byte_i == HeadB) phase_d = PhLeft;
          else if (byte_i != HeadA) phase_d = PhHunt;
        end
        PhLeft: begin
          left_d  = byte_i;
          phase_d = PhRight;
        end
        PhRight: begin
          right_d = byte_i;
          phase_d = PhTail;
        end
        default: begin
          if (byte_i == TailC) begin
            phase_d    = PhHunt;
            frame_ok_o = sides_ok;
          end else if (byte_i == HeadA) begin
            phase_d = PhHeadB;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  assign left_o  = left_q[3:0];
  assign right_o = right_q[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      left_q  <= 8'd0;
      right_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

[hw/rtl/fpsr_ring.sv]
// overwrite-oldest entry ring with pop, read-latest and flush
module fpsr_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpsr_pkg::ring_cmd_t cmd_i,
  input  fpsr_pkg::entry_t    entry_i,
  output logic                rd_ok_o,
  output fpsr_pkg::entry_t    rd_entry_o,
  output logic [3:0]          held_o
);
  import fpsr_pkg::*;

  entry_t            mem [RingDepth];
  logic [RingAw-1:0] wr_q, wr_d;
  logic [RingAw-1:0] rd_q, rd_d;
  logic [RingAw-1:0] last_slot;
  logic [RingAw-1:0] rd_addr;
  logic [RingAw-1:0] wr_nxt;
  logic [RingAw:0]   count;
  logic              empty;

  function automatic logic [RingAw-1:0] slot_next(input logic [RingAw-1:0] s);
    if (s == RingAw'(RingDepth - 1)) return '0;
    else return s + RingAw'(1);
  endfunction

  assign empty     = (rd_q == wr_q);
  assign last_slot = (wr_q == '0) ? RingAw'(RingDepth - 1) : wr_q - RingAw'(1);
  assign rd_addr   = cmd_i.latest ? last_slot : rd_q;
  assign rd_entry_o = mem[rd_addr];
  assign rd_ok_o   = (cmd_i.pop || cmd_i.latest) && !empty;
  assign wr_nxt    = slot_next(wr_q);

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (cmd_i.push) begin
      wr_d = wr_nxt;
      if (wr_nxt == rd_q) rd_d = slot_next(rd_q);
    end else if (cmd_i.pop && !empty) begin
      rd_d = slot_next(rd_q);
    end else if ((cmd_i.latest && !empty) || cmd_i.flush) begin
      rd_d = wr_q;
    end
  end

  always_comb begin
    if (wr_d >= rd_d) count = {1'b0, wr_d} - {1'b0, rd_d};
    else count = {1'b0, wr_d} + (RingAw + 1)'(RingDepth) - {1'b0, rd_d};
  end

  assign held_o = 4'(count);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule

[hw/rtl/fpsr_detector.sv]
// stability and complete-pair detector
module fpsr_detector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpsr_pkg::det_cmd_t  cmd_i,
  input  logic [7:0]          repeat_needed_i,
  input  fpsr_pkg::entry_t    entry_i,
  output fpsr_pkg::det_stat_t stat_o
);
  import fpsr_pkg::*;

  logic       armed_q, armed_d;
  logic       locked_q, locked_d;
  logic [7:0] count_q, count_d;
  logic [7:0] cand_q, cand_d;
  entry_t     stable_q, stable_d;
  logic       pair_q, pair_d;
  entry_t     pair_entry_q, pair_entry_d;
  logic [7:0] pair_code;

  assign pair_code = {entry_i.left, entry_i.right};

  always_comb begin
    armed_d      = armed_q;
    locked_d     = locked_q;
    count_d      = count_q;
    cand_d       = cand_q;
    stable_d     = stable_q;
    pair_d       = pair_q;
    pair_entry_d = pair_entry_q;
    if (cmd_i.arm || cmd_i.disarm) begin
      armed_d      = cmd_i.arm;
      locked_d     = 1'b0;
      count_d      = 8'd0;
      cand_d       = 8'd0;
      stable_d     = '0;
      pair_d       = 1'b0;
      pair_entry_d = '0;
    end else if (cmd_i.feed && armed_q) begin
      if (!pair_q && (entry_i.left != 4'd0) && (entry_i.right != 4'd0)) begin
        pair_d       = 1'b1;
        pair_entry_d = entry_i;
      end
      if (!locked_q) begin
        if ((count_q != 8'd0) && (cand_q == pair_code)) begin
          if (count_q != CountMax) count_d = count_q + 8'd1;
        end else begin
          cand_d  = pair_code;
          count_d = 8'd1;
        end
        if (count_d >= repeat_needed_i) begin
          stable_d = entry_i;
          locked_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat_o.locked       = locked_q;
    stat_o.pair_flag    = pair_q;
    stat_o.locked_nxt   = locked_d;
    stat_o.pair_nxt     = pair_d;
    stat_o.stable_entry = stable_q;
    stat_o.pair_entry   = pair_entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      locked_q     <= 1'b0;
      count_q      <= 8'd0;
      cand_q       <= 8'd0;
      stable_q     <= '0;
      pair_q       <= 1'b0;
      pair_entry_q <= '0;
    end else begin
      armed_q      <= armed_d;
      locked_q     <= locked_d;
      count_q      <= count_d;
      cand_q       <= cand_d;
      stable_q     <= stable_d;
      pair_q       <= pair_d;
      pair_entry_q <= pair_entry_d;
    end
  end

endmodule

[hw/rtl/frame_parser_stability_ring.sv]
// top level: input beat register, parser, ring, detector and result register
// Takes one beat per clock while the master side is not stalling and returns
// exactly one result beat for each. An accepted beat waits in the input register
// until the result register is free or being taken, and its result is then
// registered there. Every beat is handled in a single pass between the input
// register and the result register. The ring and detector state is updated at the
// edge that loads the result, so a following beat sees it at once. The ring has 16 slots
// and holds up to 15 frames, dropping the oldest on overflow; it needs no
// clearing pass after reset. While a finished result waits, the input register
// still takes one more beat. After that s_axis_tready stays low until
// m_axis_tready returns, and s_axis_tready follows m_axis_tready combinationally.
module frame_parser_stability_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // stable_repeat_needed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // data_byte, now_ms
  input  logic [2:0]  s_axis_tuser,    // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // out_left, out_right, out_time, entries_held,
                                       // frame_accepted, stable_locked, pair_seen
  output logic [0:0]  m_axis_tuser     // read_ok
);
  import fpsr_pkg::*;

  logic        in_valid_q;
  op_e         in_op_q;
  logic [7:0]  in_byte_q;
  logic [31:0] in_now_q;
  logic [7:0]  repeat_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_ok_q;

  logic        go;
  logic        s_accept;
  logic        frame_ok;
  logic [3:0]  p_left, p_right;
  ring_cmd_t   ring_cmd;
  det_cmd_t    det_cmd;
  det_stat_t   det_stat;
  entry_t      new_entry;
  entry_t      ring_entry;
  logic        ring_ok;
  logic [3:0]  held;
  logic        res_ok;
  entry_t      res_entry;

  assign go            = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign new_entry = '{stamp: in_now_q, left: p_left, right: p_right};

  fpsr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (go && (in_op_q == OP_BYTE)),
    .byte_i     (in_byte_q),
    .frame_ok_o (frame_ok),
    .left_o     (p_left),
    .right_o    (p_right)
  );

  always_comb begin
    ring_cmd      = '0;
    det_cmd       = '0;
    ring_cmd.push = frame_ok;
    det_cmd.feed  = frame_ok;
    if (go) begin
      case (in_op_q)
        OP_ARM: begin
          det_cmd.arm    = 1'b1;
          ring_cmd.flush = 1'b1;
        end
        OP_RELEASE: det_cmd.disarm    = 1'b1;
        OP_POP:     ring_cmd.pop      = 1'b1;
        OP_LATEST:  ring_cmd.latest   = 1'b1;
        OP_FLUSH:   ring_cmd.flush    = 1'b1;
        default: ;
      endcase
    end
  end

  fpsr_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ring_cmd),
    .entry_i    (new_entry),
    .rd_ok_o    (ring_ok),
    .rd_entry_o (ring_entry),
    .held_o     (held)
  );

  fpsr_detector u_detector (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (det_cmd),
    .repeat_needed_i (repeat_q),
    .entry_i         (new_entry),
    .stat_o          (det_stat)
  );

  always_comb begin
    res_ok    = 1'b0;
    res_entry = '0;
    case (in_op_q)
      OP_POP, OP_LATEST: begin
        res_ok    = ring_ok;
        res_entry = ring_entry;
      end
      OP_STABLE: begin
        res_ok    = det_stat.locked;
        res_entry = det_stat.stable_entry;
      end
      OP_PAIR: begin
        res_ok    = det_stat.pair_flag;
        res_entry = det_stat.pair_entry;
      end
      default: ;
    endcase
    if (!res_ok) res_entry = '0;
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata[7:0];
      in_now_q  <= s_axis_tdata[39:8];
    end
    if (go) begin
      out_ok_q   <= res_ok;
      out_data_q <= {1'b0, det_stat.pair_nxt, det_stat.locked_nxt, frame_ok, held,
                     res_entry.stamp, res_entry.right, res_entry.left};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      repeat_q    <= RepeatReset;
    end else begin
      if (s_accept) in_valid_q <= 1'b1;
      else if (go) in_valid_q <= 1'b0;
      if (go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) repeat_q <= cfg_wdata_i;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ok_q;

endmodule

[hw/rtl/fpsr_checker.sv]
// port-level checks for the frame parser stability ring, bound to the top level
module fpsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // no entry returned means zero entry fields
  a_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[39:0] == 40'd0)
    else $error("entry fields set without read_ok");

  // an accepted frame leaves at least one entry in the ring
  a_frame_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[43:40] != 4'd0)
    else $error("frame accepted but ring empty");

  // a beat that accepts a frame never returns an entry
  a_frame_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[44] |-> !m_axis_tuser[0])
    else $error("frame accepted together with read_ok");

  // an accepted input beat reaches the output when the master side is ready while it waits in the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 1'b1 |-> m_axis_tvalid)
    else $error("result beat missing after accepted beat");

endmodule

bind frame_parser_stability_ring fpsr_checker u_fpsr_checker (.*);

[dv/tb_frame_parser_stability_ring.sv]
// testbench for the frame parser stability ring: directed and random beats
module tb_frame_parser_stability_ring;
  import fpsr_pkg::*;

  typedef enum logic [2:0] {
    HUNT,
    GOT_A,
    GOT_B,
    GOT_L,
    GOT_R
  } hunt_e;

  typedef struct packed {
    logic        read_ok;
    logic [3:0]  left;
    logic [3:0]  right;
    logic [31:0] stamp;
    logic [3:0]  held;
    logic        accepted;
    logic        locked;
    logic        pair;
  } step_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  logic         gaps_on = 1'b1;
  int unsigned  error_count = 0;
  step_result_t awaited_results[$];

  logic [7:0]        repeats_needed;
  hunt_e             phase;
  logic [7:0]        hold_l, hold_r;
  entry_t            ring [RingDepth];
  logic [RingAw-1:0] wr_ptr, rd_ptr;
  logic              armed, locked, pair_flag;
  logic [7:0]        run_len, run_pair;
  entry_t            stable_ent, pair_ent;

  frame_parser_stability_ring DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_detector();
    armed      = 1'b0;
    locked     = 1'b0;
    run_len    = 8'd0;
    run_pair   = 8'd0;
    stable_ent = '0;
    pair_flag  = 1'b0;
    pair_ent   = '0;
  endfunction

  function automatic step_result_t frame_ring_step(op_e op, logic [7:0] b, logic [31:0] now);
    step_result_t res;
    entry_t       e;
    entry_t       fresh;
    res = '0;
    e   = '0;
    case (op)
      OP_BYTE: begin
        case (phase)
          HUNT: if (b == HeadA) phase = GOT_A;
          GOT_A: begin
            if (b == HeadB) phase = GOT_B;
            else if (b != HeadA) phase = HUNT;
          end
          GOT_B: begin
            hold_l = b;
            phase  = GOT_L;
          end
          GOT_L: begin
            hold_r = b;
            phase  = GOT_R;
          end
          default: begin
            if (b == TailC) begin
              phase = HUNT;
              if (hold_l <= SideMax && hold_r <= SideMax && (hold_l != 0 || hold_r != 0)) begin
                fresh = '{stamp: now, left: hold_l[3:0], right: hold_r[3:0]};
                if (armed) begin
                  if (!pair_flag && hold_l != 0 && hold_r != 0) begin
                    pair_ent  = fresh;
                    pair_flag = 1'b1;
                  end
                  if (!locked) begin
                    if (run_len != 0 && run_pair == {fresh.left, fresh.right}) begin
                      if (run_len < CountMax) run_len++;
                    end else begin
                      run_pair = {fresh.left, fresh.right};
                      run_len  = 8'd1;
                    end
                    if (run_len >= repeats_needed) begin
                      stable_ent = fresh;
                      locked     = 1'b1;
                    end
                  end
                end
                // full ring drops the oldest entry
                if (wr_ptr + 1'b1 == rd_ptr) rd_ptr++;
                ring[wr_ptr] = fresh;
                wr_ptr++;
                res.accepted = 1'b1;
              end
            end else if (b == HeadA) begin
              phase = GOT_A;
            end else begin
              phase = HUNT;
            end
          end
        endcase
      end
      OP_ARM: begin
        clear_detector();
        rd_ptr = wr_ptr;
        armed  = 1'b1;
      end
      OP_RELEASE: clear_detector();
      OP_POP: begin
        if (rd_ptr != wr_ptr) begin
          e = ring[rd_ptr];
          rd_ptr++;
          res.read_ok = 1'b1;
        end
      end
      OP_LATEST: begin
        if (rd_ptr != wr_ptr) begin
          e = ring[wr_ptr - 1'b1];
          rd_ptr = wr_ptr;
          res.read_ok = 1'b1;
        end
      end
      OP_FLUSH: rd_ptr = wr_ptr;
      OP_STABLE: begin
        if (locked) begin
          e = stable_ent;
          res.read_ok = 1'b1;
        end
      end
      default: begin
        if (pair_flag) begin
          e = pair_ent;
          res.read_ok = 1'b1;
        end
      end
    endcase
    res.left   = e.left;
    res.right  = e.right;
    res.stamp  = e.stamp;
    res.held   = wr_ptr - rd_ptr;
    res.locked = locked;
    res.pair   = pair_flag;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // predict on every accepted input beat, check every accepted result beat
  always @(posedge clk_i) begin
    step_result_t got;
    step_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) repeats_needed = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(frame_ring_step(op_e'(s_axis_tuser), s_axis_tdata[7:0],
                                                  s_axis_tdata[39:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_ok  = m_axis_tuser[0];
        got.left     = m_axis_tdata[3:0];
        got.right    = m_axis_tdata[7:4];
        got.stamp    = m_axis_tdata[39:8];
        got.held     = m_axis_tdata[43:40];
        got.accepted = m_axis_tdata[44];
        got.locked   = m_axis_tdata[45];
        got.pair     = m_axis_tdata[46];
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_ok !== want.read_ok)
            report_mismatch("read_ok", 32'(got.read_ok), 32'(want.read_ok));
          if (got.left !== want.left)
            report_mismatch("out_left", 32'(got.left), 32'(want.left));
          if (got.right !== want.right)
            report_mismatch("out_right", 32'(got.right), 32'(want.right));
          if (got.stamp !== want.stamp) report_mismatch("out_time", got.stamp, want.stamp);
          if (got.held !== want.held)
            report_mismatch("entries_held", 32'(got.held), 32'(want.held));
          if (got.accepted !== want.accepted)
            report_mismatch("frame_accepted", 32'(got.accepted), 32'(want.accepted));
          if (got.locked !== want.locked)
            report_mismatch("stable_locked", 32'(got.locked), 32'(want.locked));
          if (got.pair !== want.pair)
            report_mismatch("pair_seen", 32'(got.pair), 32'(want.pair));
        end
      end
    end
  end

  always @(posedge clk_i) m_axis_tready <= !(gaps_on && $urandom_range(99) < 27);

  task automatic send_beat(op_e op, logic [7:0] b, logic [31:0] now);
    while (gaps_on && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {now, b};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_cmd(op_e op);
    send_beat(op, 8'($urandom_range(255)), $urandom());
  endtask

  task automatic send_frame(logic [7:0] l, logic [7:0] r, logic [31:0] stamp);
    send_beat(OP_BYTE, HeadA, $urandom());
    send_beat(OP_BYTE, HeadB, $urandom());
    send_beat(OP_BYTE, l, $urandom());
    send_beat(OP_BYTE, r, $urandom());
    send_beat(OP_BYTE, TailC, stamp);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_repeats(logic [7:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_empty_reads();
    send_cmd(OP_POP);
    send_cmd(OP_LATEST);
    send_cmd(OP_STABLE);
    send_cmd(OP_PAIR);
    send_cmd(OP_FLUSH);
    send_cmd(OP_RELEASE);
  endtask

  task automatic test_frame_forms();
    send_cmd(OP_ARM);
    send_frame(SideMax, SideMax, 32'hFFFF_FFFF);
    // repeated header, then a header in the tail slot restarts the parse
    send_beat(OP_BYTE, HeadA, $urandom());
    send_beat(OP_BYTE, HeadA, $urandom());
    send_beat(OP_BYTE, HeadB, $urandom());
    send_beat(OP_BYTE, 8'd0, $urandom());
    send_beat(OP_BYTE, 8'd1, $urandom());
    send_beat(OP_BYTE, HeadA, $urandom());
    send_beat(OP_BYTE, HeadB, $urandom());
    send_beat(OP_BYTE, 8'd1, $urandom());
    send_beat(OP_BYTE, 8'd0, $urandom());
    send_beat(OP_BYTE, TailC, 32'h0000_0000);
    send_cmd(OP_STABLE);
    send_cmd(OP_PAIR);
    send_cmd(OP_LATEST);
    send_cmd(OP_POP);
  endtask

  task automatic test_ring_wrap();
    send_cmd(OP_FLUSH);
    repeat (20) send_frame(8'($urandom_range(8)), 8'($urandom_range(8, 1)), $urandom());
    repeat (16) send_cmd(OP_POP);
    repeat (3) send_frame(8'($urandom_range(8)), 8'($urandom_range(8, 1)), $urandom());
    send_cmd(OP_LATEST);
    send_cmd(OP_POP);
  endtask

  task automatic test_repeat_extremes();
    write_repeats(8'd255);
    send_cmd(OP_ARM);
    repeat (254) send_frame(8'd3, 8'd5, $urandom());
    send_cmd(OP_STABLE);
    send_frame(8'd3, 8'd5, $urandom());
    send_cmd(OP_STABLE);
    repeat (2) send_frame(8'd3, 8'd5, $urandom());
    send_cmd(OP_STABLE);
    send_cmd(OP_PAIR);
    // zero needed: first frame into an armed detector locks at once
    write_repeats(8'd0);
    send_cmd(OP_ARM);
    send_frame(8'd0, 8'd4, $urandom());
    send_cmd(OP_STABLE);
    send_cmd(OP_PAIR);
    send_frame(8'd2, 8'd2, $urandom());
    send_cmd(OP_PAIR);
    send_cmd(OP_RELEASE);
    send_cmd(OP_STABLE);
    send_frame(8'd1, 8'd1, $urandom());
    send_cmd(OP_PAIR);
    write_repeats(8'd1);
    send_cmd(OP_ARM);
    send_frame(8'd5, 8'd0, $urandom());
    send_cmd(OP_STABLE);
  endtask

  task automatic test_random_traffic();
    logic [7:0] settings [5];
    logic [7:0] fav_l, fav_r, l, r, nb;
    int         beats;
    int         pick;
    op_e        op;
    settings = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd6};
    settings[3] = 8'($urandom_range(254, 4));
    for (int p = 0; p < 5; p++) begin
      write_repeats(settings[p]);
      gaps_on <= (p != 2);
      beats = 0;
      fav_l = 8'($urandom_range(8));
      fav_r = 8'($urandom_range(8, 1));
      while (beats < 64) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          if ($urandom_range(99) < 55) begin
            l = fav_l;
            r = fav_r;
          end else begin
            l = 8'($urandom_range(8));
            r = 8'($urandom_range(8));
            if ($urandom_range(99) < 10) l = 8'($urandom_range(255, 9));
            if ($urandom_range(99) < 10) r = 8'($urandom_range(255, 9));
            if ($urandom_range(99) < 20) begin
              fav_l = l;
              fav_r = r;
            end
          end
          send_frame(l, r, $urandom());
          beats += 5;
        end else if (pick < 72) begin
          // cut-short frames and stray bytes
          send_beat(OP_BYTE, HeadA, $urandom());
          if ($urandom_range(1)) send_beat(OP_BYTE, HeadB, $urandom());
          repeat ($urandom_range(3)) begin
            nb = 8'($urandom_range(255));
            case ($urandom_range(5))
              0: nb = HeadA;
              1: nb = HeadB;
              2: nb = TailC;
              default: ;
            endcase
            send_beat(OP_BYTE, nb, $urandom());
          end
          beats += 2;
        end else begin
          pick = $urandom_range(99);
          if (pick < 32) op = OP_POP;
          else if (pick < 52) op = OP_STABLE;
          else if (pick < 72) op = OP_PAIR;
          else if (pick < 80) op = OP_LATEST;
          else if (pick < 87) op = OP_FLUSH;
          else if (pick < 94) op = OP_ARM;
          else op = OP_RELEASE;
          send_cmd(op);
          beats++;
        end
      end
    end
    gaps_on <= 1'b1;
  endtask

  initial begin
    repeats_needed = RepeatReset;
    phase          = HUNT;
    hold_l         = 8'd0;
    hold_r         = 8'd0;
    wr_ptr         = '0;
    rd_ptr         = '0;
    clear_detector();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_reads();
    test_frame_forms();
    test_ring_wrap();
    test_repeat_extremes();
    test_random_traffic();
    drain();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb_frame_parser_stability_ring: clean");
    end else begin
      $display("tb_frame_parser_stability_ring: errors");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("tb_frame_parser_stability_ring: errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/fpsr_pkg.sv
hw/rtl/fpsr_parser.sv
hw/rtl/fpsr_ring.sv
hw/rtl/fpsr_detector.sv
hw/rtl/frame_parser_stability_ring.sv
hw/rtl/fpsr_checker.sv
dv/tb_frame_parser_stability_ring.sv
